### src/assert_macros.svh
// assertion macros used by the top level of the word frequency counter
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

### src/wfc_pkg.sv
// types, codes and the delimiter test of the word frequency counter
// no dependencies
`default_nettype none
package wfc_pkg;

    localparam logic [1:0] OP_CHAR  = 2'd0;
    localparam logic [1:0] OP_FLUSH = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic KIND_COUNT = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] ch;
        logic [8:0] entry_index;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [8:0]  index;
        logic [15:0] count;
        logic        is_new;
        logic        table_full;
        logic        truncated;
        logic        out_of_range;
        logic [3:0]  word_length;
        logic [63:0] word_low;
        logic [23:0] word_high;
    } out_item_t;

    // control group of a query walking the cell chain
    typedef struct packed {
        logic valid;
        logic rd;
        logic done;
        logic is_new;
    } ctl_t;

    function automatic logic is_delim(input logic [7:0] c);
        logic d;
        case (c) inside
            8'h00, 8'h20, 8'h0a, 8'h22, 8'h2e, 8'h2c,
            8'h3b, 8'h3a, 8'h21, 8'h3f, 8'h29, 8'h28: d = 1'b1;
            default: d = 1'b0;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

### src/wfc_cell.sv
// one table entry of the word frequency counter: holds a word, its length and count
// and passes the walking query on to its neighbor; uses wfc_pkg
`default_nettype none
module wfc_cell #(
    parameter int ID             = 0,
    parameter int TABLE_ENTRIES  = 512,
    parameter int MAX_WORD_CHARS = 11,
    parameter int COUNT_BITS     = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  wfc_pkg::ctl_t                          ctl_i,
    input  logic [8*MAX_WORD_CHARS-1:0]            word_i,
    input  logic [$clog2(MAX_WORD_CHARS+1)-1:0]    len_i,
    input  logic                                   trunc_i,
    input  logic [$clog2(TABLE_ENTRIES+1)-1:0]     idx_i,
    input  logic [$clog2(TABLE_ENTRIES+1)-1:0]     used_i,
    input  logic [COUNT_BITS-1:0]                  count_i,
    output wfc_pkg::ctl_t                          ctl_o,
    output logic [8*MAX_WORD_CHARS-1:0]            word_o,
    output logic [$clog2(MAX_WORD_CHARS+1)-1:0]    len_o,
    output logic                                   trunc_o,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0]     idx_o,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0]     used_o,
    output logic [COUNT_BITS-1:0]                  count_o
);
    import wfc_pkg::*;

    localparam int WW     = 8 * MAX_WORD_CHARS;
    localparam int LEN_W  = $clog2(MAX_WORD_CHARS + 1);
    localparam int USED_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [USED_W-1:0] CELL_ID = USED_W'(ID);

    // stored entry
    logic [WW-1:0]         word_store_reg;
    logic [LEN_W-1:0]      len_store_reg;
    logic [COUNT_BITS-1:0] cnt_store_reg;

    // query stage
    ctl_t                  ctl_reg, ctl_next;
    logic [WW-1:0]         word_reg, word_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic                  trunc_reg;
    logic [USED_W-1:0]     idx_reg, idx_next;
    logic [USED_W-1:0]     used_reg;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    logic                  active;
    logic                  hit;
    logic                  ins;
    logic [COUNT_BITS-1:0] cnt_inc;

    // compare the walking word against this entry
    always_comb begin
        active  = ctl_i.valid && !ctl_i.done;
        hit     = active && !ctl_i.rd && (CELL_ID < used_i)
                  && (len_store_reg == len_i) && (word_store_reg == word_i);
        ins     = active && !ctl_i.rd && (CELL_ID == used_i);
        cnt_inc = (cnt_store_reg == {COUNT_BITS{1'b1}}) ? cnt_store_reg
                                                        : cnt_store_reg + 1'b1;
    end

    // resolve the query here or pass it on
    always_comb begin
        ctl_next   = ctl_i;
        word_next  = word_i;
        len_next   = len_i;
        idx_next   = idx_i;
        count_next = count_i;
        if (hit) begin
            ctl_next.done = 1'b1;
            idx_next      = CELL_ID;
            count_next    = cnt_inc;
        end else if (ins) begin
            ctl_next.done   = 1'b1;
            ctl_next.is_new = 1'b1;
            idx_next        = CELL_ID;
            count_next      = COUNT_BITS'(1);
        end else if (active && ctl_i.rd && (CELL_ID == idx_i)) begin
            ctl_next.done = 1'b1;
            word_next     = word_store_reg;
            len_next      = len_store_reg;
            count_next    = cnt_store_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg  <= word_next;
        len_reg   <= len_next;
        trunc_reg <= trunc_i;
        idx_reg   <= idx_next;
        used_reg  <= used_i;
        count_reg <= count_next;
        if (ins) begin
            word_store_reg <= word_i;
            len_store_reg  <= len_i;
        end
        if (ins) begin
            cnt_store_reg <= COUNT_BITS'(1);
        end else if (hit) begin
            cnt_store_reg <= cnt_inc;
        end
    end

    assign ctl_o   = ctl_reg;
    assign word_o  = word_reg;
    assign len_o   = len_reg;
    assign trunc_o = trunc_reg;
    assign idx_o   = idx_reg;
    assign used_o  = used_reg;
    assign count_o = count_reg;

endmodule
`default_nettype wire

### src/wfc_chain.sv
// row of table cells; a query enters at cell 0 and leaves after the last cell
// uses wfc_pkg and wfc_cell
`default_nettype none
module wfc_chain #(
    parameter int TABLE_ENTRIES  = 512,
    parameter int MAX_WORD_CHARS = 11,
    parameter int COUNT_BITS     = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  wfc_pkg::ctl_t                          ctl_i,
    input  logic [8*MAX_WORD_CHARS-1:0]            word_i,
    input  logic [$clog2(MAX_WORD_CHARS+1)-1:0]    len_i,
    input  logic                                   trunc_i,
    input  logic [$clog2(TABLE_ENTRIES+1)-1:0]     idx_i,
    input  logic [$clog2(TABLE_ENTRIES+1)-1:0]     used_i,
    output wfc_pkg::ctl_t                          ctl_o,
    output logic [8*MAX_WORD_CHARS-1:0]            word_o,
    output logic [$clog2(MAX_WORD_CHARS+1)-1:0]    len_o,
    output logic                                   trunc_o,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0]     idx_o,
    output logic [COUNT_BITS-1:0]                  count_o
);
    import wfc_pkg::*;

    localparam int WW     = 8 * MAX_WORD_CHARS;
    localparam int LEN_W  = $clog2(MAX_WORD_CHARS + 1);
    localparam int USED_W = $clog2(TABLE_ENTRIES + 1);

    // links between neighbors, link 0 is the chain input
    ctl_t                  ctl_l   [TABLE_ENTRIES+1];
    logic [WW-1:0]         word_l  [TABLE_ENTRIES+1];
    logic [LEN_W-1:0]      len_l   [TABLE_ENTRIES+1];
    logic                  trunc_l [TABLE_ENTRIES+1];
    logic [USED_W-1:0]     idx_l   [TABLE_ENTRIES+1];
    logic [USED_W-1:0]     used_l  [TABLE_ENTRIES+1];
    logic [COUNT_BITS-1:0] count_l [TABLE_ENTRIES+1];

    assign ctl_l[0]   = ctl_i;
    assign word_l[0]  = word_i;
    assign len_l[0]   = len_i;
    assign trunc_l[0] = trunc_i;
    assign idx_l[0]   = idx_i;
    assign used_l[0]  = used_i;
    assign count_l[0] = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        wfc_cell #(
            .ID             (g),
            .TABLE_ENTRIES  (TABLE_ENTRIES),
            .MAX_WORD_CHARS (MAX_WORD_CHARS),
            .COUNT_BITS     (COUNT_BITS)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl_i   (ctl_l[g]),
            .word_i  (word_l[g]),
            .len_i   (len_l[g]),
            .trunc_i (trunc_l[g]),
            .idx_i   (idx_l[g]),
            .used_i  (used_l[g]),
            .count_i (count_l[g]),
            .ctl_o   (ctl_l[g+1]),
            .word_o  (word_l[g+1]),
            .len_o   (len_l[g+1]),
            .trunc_o (trunc_l[g+1]),
            .idx_o   (idx_l[g+1]),
            .used_o  (used_l[g+1]),
            .count_o (count_l[g+1])
        );
    end

    assign ctl_o   = ctl_l[TABLE_ENTRIES];
    assign word_o  = word_l[TABLE_ENTRIES];
    assign len_o   = len_l[TABLE_ENTRIES];
    assign trunc_o = trunc_l[TABLE_ENTRIES];
    assign idx_o   = idx_l[TABLE_ENTRIES];
    assign count_o = count_l[TABLE_ENTRIES];

endmodule
`default_nettype wire

### src/word_frequency_counter_unit.sv
// top level of the word frequency counter: word collection, query launch, result staging
// uses wfc_pkg, wfc_chain and assert_macros.svh
//
//  channel | ports                      | payload
//  input   | s_valid, s_ready, s_item   | op, ch, entry_index
//  result  | m_valid, m_ready, m_item   | kind, index, count, flags, length, word
//
// a plain text character only adds to the pending word or marks it truncated.
// a word end with a pending word or an in-range read walks the cell chain,
// one cell per cycle, one query at a time.
// an out-of-range read skips the chain; its reply enters the hold stage directly.
// no clearing pass after reset.
// a result waiting at m_ready low parks in the hold stage; while it is full all input stalls.
`default_nettype none
module word_frequency_counter_unit #(
    parameter int TABLE_ENTRIES  = 512,
    parameter int MAX_WORD_CHARS = 11,
    parameter int COUNT_BITS     = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  wfc_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output wfc_pkg::out_item_t m_item
);
    import wfc_pkg::*;
    `include "assert_macros.svh"

    localparam int WW     = 8 * MAX_WORD_CHARS;
    localparam int LEN_W  = $clog2(MAX_WORD_CHARS + 1);
    localparam int USED_W = $clog2(TABLE_ENTRIES + 1);

    // pending word
    logic [WW-1:0]     pend_word_reg;
    logic [LEN_W-1:0]  pend_len_reg;
    logic              pend_trunc_reg;
    logic [USED_W-1:0] words_used_reg;

    // chain head
    ctl_t              head_ctl_reg;
    logic [WW-1:0]     head_word_reg;
    logic [LEN_W-1:0]  head_len_reg;
    logic              head_trunc_reg;
    logic [USED_W-1:0] head_idx_reg;
    logic              inflight_reg;

    // chain exit
    ctl_t                  x_ctl;
    logic [WW-1:0]         x_word;
    logic [LEN_W-1:0]      x_len;
    logic                  x_trunc;
    logic [USED_W-1:0]     x_idx;
    logic [COUNT_BITS-1:0] x_count;

    // result staging
    out_item_t hold_reg, hold_next;
    logic      hold_valid_reg;
    out_item_t out_reg;
    logic      out_valid_reg;

    logic accept;
    logic ends_word;
    logic launch_word;
    logic launch_read;
    logic read_oor;
    logic [63:0] x_low;
    logic [23:0] x_high;

    assign s_ready = !inflight_reg && !hold_valid_reg;
    assign accept  = s_valid && s_ready;

    always_comb begin
        ends_word   = (s_item.op == OP_FLUSH)
                      || ((s_item.op == OP_CHAR) && is_delim(s_item.ch));
        launch_word = accept && ends_word && (pend_len_reg != '0);
        read_oor    = 32'(s_item.entry_index) >= 32'(words_used_reg);
        launch_read = accept && (s_item.op == OP_READ) && !read_oor;
    end

    // pack the leaving word into the low and high output words
    always_comb begin
        x_low  = '0;
        x_high = '0;
        for (int k = 0; k < MAX_WORD_CHARS && k < 11; k++) begin
            if (k < 8) begin
                x_low[8*k +: 8] = x_word[8*k +: 8];
            end else begin
                x_high[8*(k-8) +: 8] = x_word[8*k +: 8];
            end
        end
    end

    // result formed at chain exit or for an out-of-range read
    always_comb begin
        hold_next = '0;
        if (x_ctl.valid) begin
            hold_next.word_length = 4'(x_len);
            hold_next.word_low    = x_low;
            hold_next.word_high   = x_high;
            if (x_ctl.rd) begin
                hold_next.kind  = KIND_READ;
                hold_next.index = 9'(x_idx);
                hold_next.count = 16'(x_count);
            end else begin
                hold_next.kind      = KIND_COUNT;
                hold_next.truncated = x_trunc;
                if (x_ctl.done) begin
                    hold_next.index  = 9'(x_idx);
                    hold_next.count  = 16'(x_count);
                    hold_next.is_new = x_ctl.is_new;
                end else begin
                    hold_next.table_full = 1'b1;
                end
            end
        end else begin
            hold_next.kind         = KIND_READ;
            hold_next.index        = s_item.entry_index;
            hold_next.out_of_range = 1'b1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_len_reg   <= '0;
            pend_trunc_reg <= 1'b0;
            pend_word_reg  <= '0;
            words_used_reg <= '0;
            head_ctl_reg   <= '0;
            inflight_reg   <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            head_ctl_reg <= '0;
            // collect characters of the word
            if (accept && (s_item.op == OP_CHAR) && !ends_word) begin
                if (32'(pend_len_reg) < MAX_WORD_CHARS) begin
                    for (int k = 0; k < MAX_WORD_CHARS; k++) begin
                        if (32'(pend_len_reg) == k) begin
                            pend_word_reg[8*k +: 8] <= s_item.ch;
                        end
                    end
                    pend_len_reg <= pend_len_reg + 1'b1;
                end else begin
                    pend_trunc_reg <= 1'b1;
                end
            end
            // launch a query into the chain
            if (launch_word || launch_read) begin
                head_ctl_reg.valid <= 1'b1;
                head_ctl_reg.rd    <= launch_read;
                inflight_reg       <= 1'b1;
            end
            if (launch_word) begin
                pend_word_reg  <= '0;
                pend_len_reg   <= '0;
                pend_trunc_reg <= 1'b0;
            end
            // chain exit or direct out-of-range reply into the hold stage
            if (x_ctl.valid) begin
                inflight_reg   <= 1'b0;
                hold_valid_reg <= 1'b1;
                if (!x_ctl.rd && x_ctl.is_new) begin
                    words_used_reg <= words_used_reg + 1'b1;
                end
            end else if (accept && (s_item.op == OP_READ) && read_oor) begin
                hold_valid_reg <= 1'b1;
            end
            // output register transfer
            if (hold_valid_reg && (!out_valid_reg || m_ready)) begin
                out_valid_reg  <= 1'b1;
                hold_valid_reg <= 1'b0;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (launch_word || launch_read) begin
            head_word_reg  <= pend_word_reg;
            head_len_reg   <= pend_len_reg;
            head_trunc_reg <= pend_trunc_reg;
            head_idx_reg   <= USED_W'(s_item.entry_index);
        end
        if (x_ctl.valid || (accept && (s_item.op == OP_READ) && read_oor)) begin
            hold_reg <= hold_next;
        end
        if (hold_valid_reg && (!out_valid_reg || m_ready)) begin
            out_reg <= hold_reg;
        end
    end

    wfc_chain #(
        .TABLE_ENTRIES  (TABLE_ENTRIES),
        .MAX_WORD_CHARS (MAX_WORD_CHARS),
        .COUNT_BITS     (COUNT_BITS)
    ) u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_i   (head_ctl_reg),
        .word_i  (head_word_reg),
        .len_i   (head_len_reg),
        .trunc_i (head_trunc_reg),
        .idx_i   (head_idx_reg),
        .used_i  (words_used_reg),
        .ctl_o   (x_ctl),
        .word_o  (x_word),
        .len_o   (x_len),
        .trunc_o (x_trunc),
        .idx_o   (x_idx),
        .count_o (x_count)
    );

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    `ASSERT_PROP(a_used_bound, aclk, aresetn, 32'(words_used_reg) <= TABLE_ENTRIES)
    `ASSERT_PROP(a_exit_hold_free, aclk, aresetn, x_ctl.valid |-> !hold_valid_reg)
    `ASSERT_PROP(a_exit_inflight, aclk, aresetn, x_ctl.valid |-> inflight_reg)
    `ASSERT_PROP(a_read_resolved, aclk, aresetn, (x_ctl.valid && x_ctl.rd) |-> x_ctl.done)
    `ASSERT_NEVER(a_new_and_full, aclk, aresetn, m_valid && m_item.is_new && m_item.table_full)

endmodule
`default_nettype wire

### dv/word_frequency_counter_unit_test.sv
// self-checking testbench of word_frequency_counter_unit: text, flush and read transfers
// checked against a predictor of the word table; depends on wfc_pkg and the rtl
`default_nettype none
module word_frequency_counter_unit_test;
    import wfc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES    = 512;
    localparam int WORD_CHARS = 11;
    localparam int STALL_MAX  = 4000;
    localparam int HOLD_LEN   = 900;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        in_item_t item;
        bit       drain;
    } pend_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    word_frequency_counter_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #4 aclk = ~aclk;

    pend_t     text_q[$];
    out_item_t report_q[$];
    int        errors = 0;
    int        reports_seen = 0;
    int        items_sent = 0;
    bit        idle_on = 1'b0;
    bit        in_fire = 1'b0;

    // predictor state: pending word and the distinct-word table
    logic [87:0] cur_word;
    int          cur_len;
    bit          cur_trunc;
    logic [87:0] tbl_word [ENTRIES];
    int          tbl_len [ENTRIES];
    logic [15:0] tbl_cnt [ENTRIES];
    int          words_stored;

    function automatic bit is_sep(logic [7:0] c);
        return c == 8'h00 || c == 8'h20 || c == 8'h0a || c == 8'h22 || c == 8'h2e ||
               c == 8'h2c || c == 8'h3b || c == 8'h3a || c == 8'h21 || c == 8'h3f ||
               c == 8'h29 || c == 8'h28;
    endfunction

    // word end: look up, bump or insert, build the count report
    function automatic bit close_word(output out_item_t r);
        int at;
        r = '0;
        if (cur_len == 0) return 1'b0;
        at = -1;
        for (int i = 0; i < words_stored; i++)
            if (at < 0 && tbl_len[i] == cur_len && tbl_word[i] == cur_word) at = i;
        r.kind = KIND_COUNT;
        if (at >= 0) begin
            if (tbl_cnt[at] != 16'hffff) tbl_cnt[at]++;
            r.index = at[8:0];
            r.count = tbl_cnt[at];
        end else if (words_stored < ENTRIES) begin
            tbl_word[words_stored] = cur_word;
            tbl_len[words_stored]  = cur_len;
            tbl_cnt[words_stored]  = 16'd1;
            r.index  = words_stored[8:0];
            r.count  = 16'd1;
            r.is_new = 1'b1;
            words_stored++;
        end else begin
            r.table_full = 1'b1;
        end
        r.truncated   = cur_trunc;
        r.word_length = cur_len[3:0];
        r.word_low    = cur_word[63:0];
        r.word_high   = cur_word[87:64];
        cur_word  = '0;
        cur_len   = 0;
        cur_trunc = 1'b0;
        return 1'b1;
    endfunction

    function automatic void predict_item(in_item_t it);
        out_item_t r;
        int        idx;
        r = '0;
        case (it.op)
            OP_CHAR: begin
                if (is_sep(it.ch)) begin
                    if (close_word(r)) report_q.push_back(r);
                end else if (cur_len < WORD_CHARS) begin
                    cur_word[8*cur_len +: 8] = it.ch;
                    cur_len++;
                end else begin
                    cur_trunc = 1'b1;
                end
            end
            OP_FLUSH: if (close_word(r)) report_q.push_back(r);
            OP_READ: begin
                idx     = it.entry_index;
                r.kind  = KIND_READ;
                r.index = it.entry_index;
                if (idx >= words_stored) begin
                    r.out_of_range = 1'b1;
                end else begin
                    r.count       = tbl_cnt[idx];
                    r.word_length = tbl_len[idx][3:0];
                    r.word_low    = tbl_word[idx][63:0];
                    r.word_high   = tbl_word[idx][87:64];
                end
                report_q.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // input side: accept at the rising edge, predict right away
    always @(posedge aclk) begin
        in_fire <= s_valid && s_ready && aresetn;
        if (aresetn && s_valid && s_ready) begin
            predict_item(s_item);
            items_sent++;
        end
    end

    // driver: offer the next pending item at the falling edge
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_fire)) begin
            if (text_q.size() > 0 && !(idle_on && $urandom_range(99) < 37) &&
                !(text_q[0].drain && (report_q.size() > 0 || in_fire))) begin
                s_item  <= text_q[0].item;
                s_valid <= 1'b1;
                void'(text_q.pop_front());
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random back-pressure plus one long hold-off
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!hold_done && reports_seen == 30) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= !(idle_on && $urandom_range(99) < 37);
        end
    end

    // monitor: compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            reports_seen <= reports_seen + 1;
            if (report_q.size() == 0) begin
                $display("%0t: unexpected result %p", $realtime, m_item);
                errors++;
            end else begin
                e = report_q.pop_front();
                if (m_item !== e) begin
                    errors++;
                    if (m_item.kind !== e.kind)
                        $display("%0t: kind exp %0h got %0h", $realtime, e.kind, m_item.kind);
                    if (m_item.index !== e.index)
                        $display("%0t: index exp %0d got %0d", $realtime, e.index, m_item.index);
                    if (m_item.count !== e.count)
                        $display("%0t: count exp %0d got %0d", $realtime, e.count, m_item.count);
                    if (m_item.is_new !== e.is_new)
                        $display("%0t: is_new exp %0b got %0b", $realtime, e.is_new,
                                 m_item.is_new);
                    if (m_item.table_full !== e.table_full)
                        $display("%0t: table_full exp %0b got %0b", $realtime, e.table_full,
                                 m_item.table_full);
                    if (m_item.truncated !== e.truncated)
                        $display("%0t: truncated exp %0b got %0b", $realtime, e.truncated,
                                 m_item.truncated);
                    if (m_item.out_of_range !== e.out_of_range)
                        $display("%0t: out_of_range exp %0b got %0b", $realtime,
                                 e.out_of_range, m_item.out_of_range);
                    if (m_item.word_length !== e.word_length)
                        $display("%0t: word_length exp %0d got %0d", $realtime,
                                 e.word_length, m_item.word_length);
                    if (m_item.word_low !== e.word_low)
                        $display("%0t: word_low exp %h got %h", $realtime, e.word_low,
                                 m_item.word_low);
                    if (m_item.word_high !== e.word_high)
                        $display("%0t: word_high exp %h got %h", $realtime, e.word_high,
                                 m_item.word_high);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_MAX) begin
            $display("%0t: no transfer for %0d cycles", $realtime, quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_item(logic [1:0] op, logic [7:0] c, logic [8:0] idx, bit drain = 0);
        pend_t p;
        p.item.op          = op;
        p.item.ch          = c;
        p.item.entry_index = idx;
        p.drain            = drain;
        text_q.push_back(p);
    endtask

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (is_sep(c));
        return c;
    endfunction

    function automatic logic [7:0] any_sep();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (!is_sep(c));
        return c;
    endfunction

    logic [7:0] vocab [16][14];
    int         vocab_len [16];

    initial begin
        int sel;
        int n;
        cur_word = '0;
        cur_len = 0;
        cur_trunc = 1'b0;
        words_stored = 0;

        // directed: every delimiter, empty words, high bytes, reads, unused op
        add_item(OP_READ, 8'h00, 9'd0);
        add_item(OP_CHAR, 8'h78, 9'd0);
        for (int c = 0; c < 256; c++)
            if (is_sep(8'(c))) add_item(OP_CHAR, 8'(c), 9'd0);
        add_item(OP_FLUSH, 8'h00, 9'd0);
        add_item(OP_CHAR, 8'hff, 9'd0);
        add_item(OP_CHAR, 8'h80, 9'd0);
        add_item(OP_FLUSH, 8'h00, 9'd0);
        add_item(OP_UNUSED, 8'hff, 9'h1ff);
        add_item(OP_READ, 8'h00, 9'd1);
        add_item(OP_READ, 8'h00, 9'd511);

        // random text over a small vocabulary, with long words and noise
        foreach (vocab[w]) begin
            vocab_len[w] = (w < 3) ? $urandom_range(12, 14) : $urandom_range(1, 11);
            for (int k = 0; k < 14; k++) vocab[w][k] = word_char();
        end
        while (text_q.size() < 940) begin
            sel = $urandom_range(99);
            if (sel < 72) begin
                n = $urandom_range(15);
                for (int k = 0; k < vocab_len[n]; k++) add_item(OP_CHAR, vocab[n][k], 9'd0);
                add_item(OP_CHAR, any_sep(), 9'($urandom_range(511)));
            end else if (sel < 78) begin
                n = $urandom_range(1, 14);
                for (int k = 0; k < n; k++) add_item(OP_CHAR, word_char(), 9'd0);
                add_item(OP_FLUSH, 8'($urandom_range(255)), 9'($urandom_range(511)));
            end else if (sel < 88) begin
                add_item(OP_READ, 8'($urandom_range(255)),
                         ($urandom_range(3) == 0) ? 9'($urandom_range(511))
                                                  : 9'($urandom_range(20)));
            end else if (sel < 93) begin
                add_item(OP_FLUSH, 8'($urandom_range(255)), 9'($urandom_range(511)));
            end else if (sel < 96) begin
                add_item(OP_UNUSED, 8'($urandom_range(255)), 9'($urandom_range(511)));
            end else begin
                add_item(OP_CHAR, 8'($urandom_range(255)), 9'($urandom_range(511)));
            end
        end
        add_item(OP_FLUSH, 8'h00, 9'd0);

        // after a full drain: reads around the end of the table and repeats
        add_item(OP_READ, 8'h00, 9'd511, 1'b1);
        add_item(OP_READ, 8'h00, 9'd0);
        for (int k = 0; k < 14; k++) add_item(OP_CHAR, vocab[0][k], 9'd0);
        add_item(OP_FLUSH, 8'h00, 9'd0);
        for (int k = 0; k < 12; k++) add_item(OP_READ, 8'h00, 9'($urandom_range(511)));

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        idle_on = 1'b1;
        // stretch with no idling on either side
        wait (text_q.size() < 700);
        idle_on = 1'b0;
        wait (text_q.size() < 400);
        idle_on = 1'b1;
        wait (text_q.size() == 0 && !s_valid);
        wait (report_q.size() == 0);
        repeat (600) @(posedge aclk);

        $display("%0d input transfers, %0d results checked, %0d words in the table",
                 items_sent, reports_seen, words_stored);
        $display("covered delimiters, flushes, reads in and out of range, long and repeated words");
        if (errors == 0 && report_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
`default_nettype wire
